// ===== rtl/qts_pkg.sv =====
// qts_pkg: widths, operation codes, item and handshake structs and the
// sign-extension, halving and saturating helpers shared by the quintic trajectory sampler.
// No dependencies.
`default_nettype none
package qts_pkg;
   localparam int FRAC_BITS    = 16;
   localparam int DATA_W       = 32;
   localparam int DUR_W        = 31;
   localparam int IDX_W        = 10;
   localparam int SCNT_W       = 11;
   localparam int WIDE_W       = 64;
   localparam int MAG_W        = WIDE_W - 1;
   localparam int MUL_W        = 31;
   localparam int NUM_W        = MAG_W + MUL_W;
   localparam int DIVC_W       = $clog2(NUM_W);
   localparam int COMBO_W      = 40;
   localparam int KMUL_W       = 5;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RESET = SCNT_W'(100);
   localparam logic [MUL_W-1:0]  ONE_M = MUL_W'(1) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {MAG_W{1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(MAG_W-1){1'b0}}, 1'b1};

   localparam logic [1:0] OP_MT = 2'd0;
   localparam logic [1:0] OP_MK = 2'd1;
   localparam logic [1:0] OP_MS = 2'd2;
   localparam logic [1:0] OP_MD = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0]  q0;
      logic signed [DATA_W-1:0]  dq0;
      logic signed [DATA_W-1:0]  ddq0;
      logic signed [COMBO_W-1:0] e3;
      logic signed [COMBO_W-1:0] e4;
      logic signed [COMBO_W-1:0] e5;
      logic signed [COMBO_W-1:0] f3;
      logic signed [COMBO_W-1:0] f4;
      logic signed [COMBO_W-1:0] f5;
      logic signed [COMBO_W-1:0] g3;
      logic signed [COMBO_W-1:0] g4;
      logic signed [COMBO_W-1:0] g5;
      logic [DUR_W-1:0]          dur;
      logic [IDX_W-1:0]          idx_i;
      logic [SCNT_W-1:0]         idx_n;
      logic [IDX_W-1:0]          echo;
      logic                      ov;
   } item_type;

   typedef struct packed {
      logic                     start;
      logic [1:0]               op;
      logic [KMUL_W-1:0]        k;
      logic signed [WIDE_W-1:0] x;
      logic [DUR_W-1:0]         dur;
      logic [IDX_W-1:0]         si;
      logic [SCNT_W-1:0]        sn;
   } mdreq_type;

   typedef struct packed {
      logic                     done;
      logic                     ov;
      logic signed [WIDE_W-1:0] y;
   } mdrsp_type;

   typedef struct packed {
      logic                     ov;
      logic signed [WIDE_W-1:0] val;
   } wide_type;

   typedef struct packed {
      logic                     ov;
      logic signed [DATA_W-1:0] val;
   } out32_type;

   function automatic logic signed [WIDE_W-1:0] sx32(input logic signed [DATA_W-1:0] v);
      return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [WIDE_W-1:0] sxc(input logic signed [COMBO_W-1:0] v);
      return {{(WIDE_W-COMBO_W){v[COMBO_W-1]}}, v};
   endfunction

   function automatic wide_type sat_add(input logic signed [WIDE_W-1:0] a,
                                        input logic signed [WIDE_W-1:0] b);
      logic [WIDE_W:0] s;
      wide_type r;
      s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      r.ov  = 1'b0;
      r.val = s[WIDE_W-1:0];
      if (!s[WIDE_W] && s[WIDE_W-1]) begin
         r.ov  = 1'b1;
         r.val = WIDE_MAX;
      end else if (s[WIDE_W] && (!s[WIDE_W-1] || (s[WIDE_W-2:0] == '0))) begin
         r.ov  = 1'b1;
         r.val = WIDE_MIN;
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] half(input logic signed [WIDE_W-1:0] x);
      logic [WIDE_W-1:0] s;
      s = x + {{(WIDE_W-1){1'b0}}, x[WIDE_W-1]};
      return {s[WIDE_W-1], s[WIDE_W-1:1]};
   endfunction

   function automatic out32_type clamp32(input logic signed [WIDE_W-1:0] x);
      out32_type r;
      r.ov  = 1'b0;
      r.val = x[DATA_W-1:0];
      if (x[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){x[WIDE_W-1]}}) begin
         r.ov  = 1'b1;
         r.val = x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/qts_if.sv =====
// qts_if: valid/ready channel interfaces for requests, results and the
// sample count register write. Depends on qts_pkg.
`default_nettype none
interface qts_req_if;
   logic valid;
   logic ready;
   logic signed [qts_pkg::DATA_W-1:0] start_position;
   logic signed [qts_pkg::DATA_W-1:0] end_position;
   logic signed [qts_pkg::DATA_W-1:0] start_velocity;
   logic signed [qts_pkg::DATA_W-1:0] end_velocity;
   logic signed [qts_pkg::DATA_W-1:0] start_acceleration;
   logic signed [qts_pkg::DATA_W-1:0] end_acceleration;
   logic [qts_pkg::DUR_W-1:0]         duration;
   logic [qts_pkg::IDX_W-1:0]         sample_index;
   modport source (output valid, start_position, end_position, start_velocity,
                   end_velocity, start_acceleration, end_acceleration, duration,
                   sample_index, input ready);
   modport sink   (input valid, start_position, end_position, start_velocity,
                   end_velocity, start_acceleration, end_acceleration, duration,
                   sample_index, output ready);
endinterface

interface qts_rsp_if;
   logic valid;
   logic ready;
   logic signed [qts_pkg::DATA_W-1:0] position;
   logic signed [qts_pkg::DATA_W-1:0] velocity;
   logic signed [qts_pkg::DATA_W-1:0] acceleration;
   logic [qts_pkg::IDX_W-1:0]         sample_echo;
   logic                              overflow;
   modport source (output valid, position, velocity, acceleration, sample_echo,
                   overflow, input ready);
   modport sink   (input valid, position, velocity, acceleration, sample_echo,
                   overflow, output ready);
endinterface

interface qts_csr_if;
   logic valid;
   logic ready;
   logic [qts_pkg::SCNT_W-1:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/qts_front.sv =====
// qts_front: accepts request transactions, range-checks the index and forms
// the linear coefficient terms. Depends on qts_pkg and qts_if.
`default_nettype none
module qts_front (
   qts_req_if.sink                  req,
   input  logic [qts_pkg::SCNT_W-1:0] sample_count,
   input  logic                     space,
   output logic                     push,
   output qts_pkg::item_type        item
);
   import qts_pkg::*;

   logic [DATA_W:0]           d;
   logic signed [COMBO_W-1:0] dx;
   logic signed [COMBO_W-1:0] dq0_x;
   logic signed [COMBO_W-1:0] dqf_x;
   logic signed [COMBO_W-1:0] ddq0_x;
   logic signed [COMBO_W-1:0] ddqf_x;
   logic                      oob;

   assign req.ready = space;
   assign push      = req.valid & space;

   assign d      = {req.end_position[DATA_W-1], req.end_position}
                 - {req.start_position[DATA_W-1], req.start_position};
   assign dx     = {{(COMBO_W-DATA_W-1){d[DATA_W]}}, d};
   assign dq0_x  = {{(COMBO_W-DATA_W){req.start_velocity[DATA_W-1]}}, req.start_velocity};
   assign dqf_x  = {{(COMBO_W-DATA_W){req.end_velocity[DATA_W-1]}}, req.end_velocity};
   assign ddq0_x = {{(COMBO_W-DATA_W){req.start_acceleration[DATA_W-1]}},
                    req.start_acceleration};
   assign ddqf_x = {{(COMBO_W-DATA_W){req.end_acceleration[DATA_W-1]}},
                    req.end_acceleration};
   assign oob    = {1'b0, req.sample_index} >= sample_count;

   always_comb begin
      item.q0    = req.start_position;
      item.dq0   = req.start_velocity;
      item.ddq0  = req.start_acceleration;
      item.e3    = 8 * dqf_x + 12 * dq0_x;
      item.e4    = 14 * dqf_x + 16 * dq0_x;
      item.e5    = 6 * dqf_x + 6 * dq0_x;
      item.f3    = 3 * ddq0_x - ddqf_x;
      item.f4    = 3 * ddq0_x - 2 * ddqf_x;
      item.f5    = ddq0_x - ddqf_x;
      item.g3    = 20 * dx;
      item.g4    = -30 * dx;
      item.g5    = 12 * dx;
      item.dur   = (req.duration == '0) ? DUR_W'(1) : req.duration;
      item.idx_i = oob ? IDX_W'(1) : req.sample_index;
      item.idx_n = oob ? SCNT_W'(1) : sample_count;
      item.echo  = req.sample_index;
      item.ov    = oob;
   end
endmodule
`default_nettype wire

// ===== rtl/qts_queue.sv =====
// qts_queue: short item queue between the front and the sequencer.
// Depends on qts_pkg.
`default_nettype none
module qts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qts_pkg::item_type item_in,
   output logic              space,
   input  logic              pop,
   output logic              valid,
   output qts_pkg::item_type item_out
);
   import qts_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign space    = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign item_out = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/qts_muldiv.sv =====
// qts_muldiv: shared saturating unit computing trunc(x*m/d), or trunc(x*m/2^16) for OP_MT,
// with a split multiplier and a bit-serial restoring divider. Depends on qts_pkg.
`default_nettype none
module qts_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  qts_pkg::mdreq_type mreq,
   output qts_pkg::mdrsp_type mrsp
);
   import qts_pkg::*;

   localparam logic [2:0] MD_IDLE   = 3'd0;
   localparam logic [2:0] MD_MUL_LO = 3'd1;
   localparam logic [2:0] MD_MUL_HI = 3'd2;
   localparam logic [2:0] MD_DIV    = 3'd3;
   localparam logic [2:0] MD_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [MUL_W-1:0]  m_ff, m_in;
   logic [MUL_W-1:0]  d_ff, d_in;
   logic [MAG_W-1:0]  prod_ff, prod_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [MUL_W-1:0]  rem_ff, rem_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;

   logic [WIDE_W-1:0]      negx;
   logic [MAG_W-1:0]       lo_mul;
   logic [2*MUL_W-1:0]     hi_mul;
   logic [NUM_W-1:0]       num_full;
   logic [MUL_W:0]         rem_sh;
   logic [MUL_W:0]         rem_diff;
   logic                   sat;
   logic [MAG_W-1:0]       mag_r;

   assign negx     = -mreq.x;
   assign lo_mul   = mag_ff[DATA_W-1:0] * m_ff;
   assign hi_mul   = mag_ff[MAG_W-1:DATA_W] * m_ff;
   assign num_full = {hi_mul, {DATA_W{1'b0}}} + {{(NUM_W-MAG_W){1'b0}}, prod_ff};
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         MD_IDLE: begin
            if (mreq.start) begin
               op_in  = mreq.op;
               neg_in = mreq.x[WIDE_W-1];
               mag_in = mreq.x[WIDE_W-1] ? negx[MAG_W-1:0] : mreq.x[MAG_W-1:0];
               d_in   = MUL_W'(1);
               case (mreq.op)
                  OP_MT:   m_in = mreq.dur;
                  OP_MK:   m_in = {{(MUL_W-KMUL_W){1'b0}}, mreq.k};
                  OP_MS: begin
                     m_in = {{(MUL_W-IDX_W){1'b0}}, mreq.si};
                     d_in = {{(MUL_W-SCNT_W){1'b0}}, mreq.sn};
                  end
                  default: begin
                     m_in = ONE_M;
                     d_in = mreq.dur;
                  end
               endcase
               state_in = MD_MUL_LO;
            end
         end
         MD_MUL_LO: begin
            prod_in  = lo_mul;
            state_in = MD_MUL_HI;
         end
         MD_MUL_HI: begin
            case (op_ff)
               OP_MT: begin
                  num_in   = num_full >> FRAC_BITS;
                  state_in = MD_DONE;
               end
               OP_MK: begin
                  num_in   = num_full;
                  state_in = MD_DONE;
               end
               default: begin
                  num_in   = num_full;
                  rem_in   = '0;
                  cnt_in   = DIVC_W'(NUM_W-1);
                  state_in = MD_DIV;
               end
            endcase
         end
         MD_DIV: begin
            if (!rem_diff[MUL_W]) begin
               rem_in = rem_diff[MUL_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[MUL_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = MD_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      m_ff    <= m_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign sat   = num_ff[NUM_W-1:MAG_W] != '0;
   assign mag_r = sat ? {MAG_W{1'b1}} : num_ff[MAG_W-1:0];

   always_comb begin
      mrsp.done = state_ff == MD_DONE;
      mrsp.ov   = sat;
      mrsp.y    = neg_ff ? -{1'b0, mag_r} : {1'b0, mag_r};
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> (state_ff == MD_IDLE))
      else $error("operation started while unit busy");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MD_DIV) |-> (d_ff != '0))
      else $error("division by zero");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MD_DONE) |=> (state_ff == MD_IDLE))
      else $error("result held longer than one cycle");
`endif
endmodule
`default_nettype wire

// ===== rtl/qts_back.sv =====
// qts_back: sequencer that builds the scaled coefficients and runs the three
// Horner chains on the shared unit, then clamps into the result register.
// Depends on qts_pkg and qts_if.
`default_nettype none
module qts_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  qts_pkg::item_type  item,
   output logic               pop,
   output qts_pkg::mdreq_type mreq,
   input  qts_pkg::mdrsp_type mrsp,
   qts_rsp_if.source          rsp
);
   import qts_pkg::*;

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_B1   = 6'd1;
   localparam logic [5:0] S_B2A  = 6'd2;
   localparam logic [5:0] S_B2B  = 6'd3;
   localparam logic [5:0] S_B3A  = 6'd4;
   localparam logic [5:0] S_B3B  = 6'd5;
   localparam logic [5:0] S_B3C  = 6'd6;
   localparam logic [5:0] S_B4A  = 6'd7;
   localparam logic [5:0] S_B4B  = 6'd8;
   localparam logic [5:0] S_B4C  = 6'd9;
   localparam logic [5:0] S_B5A  = 6'd10;
   localparam logic [5:0] S_B5B  = 6'd11;
   localparam logic [5:0] S_B5C  = 6'd12;
   localparam logic [5:0] S_P1   = 6'd13;
   localparam logic [5:0] S_P2   = 6'd14;
   localparam logic [5:0] S_P3   = 6'd15;
   localparam logic [5:0] S_P4   = 6'd16;
   localparam logic [5:0] S_P5   = 6'd17;
   localparam logic [5:0] S_V1   = 6'd18;
   localparam logic [5:0] S_V2   = 6'd19;
   localparam logic [5:0] S_V3   = 6'd20;
   localparam logic [5:0] S_V4   = 6'd21;
   localparam logic [5:0] S_V5   = 6'd22;
   localparam logic [5:0] S_V6   = 6'd23;
   localparam logic [5:0] S_V7   = 6'd24;
   localparam logic [5:0] S_V8   = 6'd25;
   localparam logic [5:0] S_V9   = 6'd26;
   localparam logic [5:0] S_A1   = 6'd27;
   localparam logic [5:0] S_A2   = 6'd28;
   localparam logic [5:0] S_A3   = 6'd29;
   localparam logic [5:0] S_A4   = 6'd30;
   localparam logic [5:0] S_A5   = 6'd31;
   localparam logic [5:0] S_A6   = 6'd32;
   localparam logic [5:0] S_A7   = 6'd33;
   localparam logic [5:0] S_A8   = 6'd34;
   localparam logic [5:0] S_A9   = 6'd35;
   localparam logic [5:0] S_OUT  = 6'd36;

   logic [5:0]               step_ff, step_in;
   logic                     wait_ff, wait_in;
   logic                     ov_ff, ov_in;
   item_type                 item_ff, item_in;
   logic signed [WIDE_W-1:0] b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic signed [WIDE_W-1:0] b4_ff, b4_in, b5_ff, b5_in;
   logic signed [WIDE_W-1:0] tmp_ff, tmp_in, tmp2_ff, tmp2_in;
   logic signed [WIDE_W-1:0] acc_ff, acc_in, p_ff, p_in, v_ff, v_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] pos_ff, pos_in, vel_ff, vel_in, accel_ff, accel_in;
   logic [IDX_W-1:0]         echo_ff, echo_in;
   logic                     ovf_ff, ovf_in;

   logic                     arith;
   logic signed [WIDE_W-1:0] x_sel;
   logic [1:0]               op_sel;
   logic [KMUL_W-1:0]        k_sel;
   logic signed [WIDE_W-1:0] sum_a;
   logic                     use_sum;
   wide_type                 iss_sum;
   logic signed [WIDE_W-1:0] post_a;
   logic                     post_neg;
   wide_type                 post_sum;
   logic signed [WIDE_W-1:0] y;
   wide_type                 p_fin;
   out32_type                cp, cv, ca;

   assign arith = (step_ff != S_IDLE) && (step_ff != S_OUT);
   assign y     = mrsp.y;

   // operand selection for the shared unit
   always_comb begin
      x_sel   = tmp_ff;
      op_sel  = OP_MT;
      k_sel   = '0;
      sum_a   = tmp_ff;
      use_sum = 1'b0;
      case (step_ff)
         S_B1:  x_sel = sx32(item_ff.dq0);
         S_B2A: x_sel = sx32(item_ff.ddq0);
         S_B2B: x_sel = tmp_ff;
         S_B3A: x_sel = sxc(item_ff.e3);
         S_B3B: x_sel = sxc(item_ff.f3);
         S_B3C: x_sel = tmp2_ff;
         S_B4A: x_sel = sxc(item_ff.e4);
         S_B4B: x_sel = sxc(item_ff.f4);
         S_B4C: x_sel = tmp2_ff;
         S_B5A: x_sel = sxc(item_ff.e5);
         S_B5B: x_sel = sxc(item_ff.f5);
         S_B5C: x_sel = tmp2_ff;
         S_P1: begin
            x_sel  = b5_ff;
            op_sel = OP_MS;
         end
         S_P2: begin
            sum_a = b4_ff; use_sum = 1'b1; op_sel = OP_MS;
         end
         S_P3: begin
            sum_a = b3_ff; use_sum = 1'b1; op_sel = OP_MS;
         end
         S_P4: begin
            sum_a = b2_ff; use_sum = 1'b1; op_sel = OP_MS;
         end
         S_P5: begin
            sum_a = b1_ff; use_sum = 1'b1; op_sel = OP_MS;
         end
         S_V1: begin
            x_sel = b5_ff; op_sel = OP_MK; k_sel = KMUL_W'(5);
         end
         S_V2, S_A2: begin
            x_sel = tmp_ff; op_sel = OP_MS;
         end
         S_V3: begin
            x_sel = b4_ff; op_sel = OP_MK; k_sel = KMUL_W'(4);
         end
         S_V4, S_V6, S_V8, S_A4, S_A6: begin
            sum_a = tmp_ff; use_sum = 1'b1; op_sel = OP_MS;
         end
         S_V5: begin
            x_sel = b3_ff; op_sel = OP_MK; k_sel = KMUL_W'(3);
         end
         S_V7, S_A7: begin
            x_sel = b2_ff; op_sel = OP_MK; k_sel = KMUL_W'(2);
         end
         S_V9: begin
            sum_a = b1_ff; use_sum = 1'b1; op_sel = OP_MD;
         end
         S_A1: begin
            x_sel = b5_ff; op_sel = OP_MK; k_sel = KMUL_W'(20);
         end
         S_A3: begin
            x_sel = b4_ff; op_sel = OP_MK; k_sel = KMUL_W'(12);
         end
         S_A5: begin
            x_sel = b3_ff; op_sel = OP_MK; k_sel = KMUL_W'(6);
         end
         S_A8: begin
            sum_a = tmp_ff; use_sum = 1'b1; op_sel = OP_MD;
         end
         S_A9: begin
            x_sel = acc_ff; op_sel = OP_MD;
         end
         default: ;
      endcase
   end

   assign iss_sum = sat_add(sum_a, acc_ff);

   always_comb begin
      mreq.start = arith && !wait_ff;
      mreq.op    = op_sel;
      mreq.k     = k_sel;
      mreq.x     = use_sum ? iss_sum.val : x_sel;
      mreq.dur   = item_ff.dur;
      mreq.si    = item_ff.idx_i;
      mreq.sn    = item_ff.idx_n;
   end

   // coefficient assembly after a unit result
   always_comb begin
      post_a   = tmp_ff;
      post_neg = 1'b0;
      case (step_ff)
         S_B3A: begin
            post_a = sxc(item_ff.g3); post_neg = 1'b1;
         end
         S_B3C, S_B5C: post_neg = 1'b1;
         S_B4A: post_a = sxc(item_ff.g4);
         S_B5A: begin
            post_a = sxc(item_ff.g5); post_neg = 1'b1;
         end
         default: ;
      endcase
   end

   assign post_sum = sat_add(post_a, post_neg ? -y : y);
   assign p_fin    = sat_add(sx32(item_ff.q0), p_ff);
   assign cp       = clamp32(p_fin.val);
   assign cv       = clamp32(v_ff);
   assign ca       = clamp32(acc_ff);

   always_comb begin
      step_in      = step_ff;
      wait_in      = wait_ff;
      ov_in        = ov_ff;
      item_in      = item_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      tmp_in       = tmp_ff;
      tmp2_in      = tmp2_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      accel_in     = accel_ff;
      echo_in      = echo_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      if (step_ff == S_IDLE) begin
         if (item_valid) begin
            item_in = item;
            ov_in   = item.ov;
            pop     = 1'b1;
            wait_in = 1'b0;
            step_in = S_B1;
         end
      end else if (step_ff == S_OUT) begin
         if (!rsp_valid_ff || rsp.ready) begin
            pos_in       = cp.val;
            vel_in       = cv.val;
            accel_in     = ca.val;
            echo_in      = item_ff.echo;
            ovf_in       = ov_ff | p_fin.ov | cp.ov | cv.ov | ca.ov;
            rsp_valid_in = 1'b1;
            step_in      = S_IDLE;
         end
      end else if (!wait_ff) begin
         wait_in = 1'b1;
         ov_in   = ov_ff | (use_sum & iss_sum.ov);
      end else if (mrsp.done) begin
         wait_in = 1'b0;
         step_in = step_ff + 1'b1;
         ov_in   = ov_ff | mrsp.ov;
         case (step_ff)
            S_B1:  b1_in = y;
            S_B2A, S_B3B, S_B4B, S_B5B: begin
               if (step_ff == S_B2A) begin
                  tmp_in = y;
               end else begin
                  tmp2_in = y;
               end
            end
            S_B2B: b2_in = half(y);
            S_B3A, S_B4A, S_B5A: begin
               tmp_in = post_sum.val;
               ov_in  = ov_ff | mrsp.ov | post_sum.ov;
            end
            S_B3C: begin
               b3_in = half(post_sum.val);
               ov_in = ov_ff | mrsp.ov | post_sum.ov;
            end
            S_B4C: begin
               b4_in = half(post_sum.val);
               ov_in = ov_ff | mrsp.ov | post_sum.ov;
            end
            S_B5C: begin
               b5_in = half(post_sum.val);
               ov_in = ov_ff | mrsp.ov | post_sum.ov;
            end
            S_P5:  p_in = y;
            S_V9:  v_in = y;
            S_V1, S_V3, S_V5, S_V7, S_A1, S_A3, S_A5, S_A7: tmp_in = y;
            default: acc_in = y;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ov_ff    <= ov_in;
      item_ff  <= item_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      b3_ff    <= b3_in;
      b4_ff    <= b4_in;
      b5_ff    <= b5_in;
      tmp_ff   <= tmp_in;
      tmp2_ff  <= tmp2_in;
      acc_ff   <= acc_in;
      p_ff     <= p_in;
      v_ff     <= v_in;
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
      accel_ff <= accel_in;
      echo_ff  <= echo_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.position     = pos_ff;
   assign rsp.velocity     = vel_ff;
   assign rsp.acceleration = accel_ff;
   assign rsp.sample_echo  = echo_ff;
   assign rsp.overflow     = ovf_ff;

`ifndef ASSERT_OFF
   a_done_awaited: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> (wait_ff && arith))
      else $error("unit result with no operation pending");
   a_divisors_set: assert property (@(posedge clock) disable iff (reset)
      arith |-> ((item_ff.idx_n != '0) && (item_ff.dur != '0)))
      else $error("zero divisor in active item");
   a_out_quiet: assert property (@(posedge clock) disable iff (reset)
      (step_ff == S_OUT) |-> (!wait_ff && !mreq.start))
      else $error("unit still in use at result stage");
`endif
endmodule
`default_nettype wire

// ===== rtl/quintic_trajectory_sampler.sv =====
// Quintic trajectory sampler, top level.
// req_bus carries one joint segment (boundary positions, velocities and
// accelerations, duration, sample index) per transaction; rsp_bus returns
// position, velocity and acceleration at t = index*duration/sample_count,
// Q16.16, saturated, with the index echoed and an overflow flag.
// csr_bus writes sample_count; it is always ready and must only be used
// while no transaction is in flight.
// An item runs 35 operations in turn on one shared multiply-divide unit,
// 20 of them multiply-only and 15 that also go through its 94-step
// bit-serial divider, besides the steps that take the item from the queue
// and load the result register. Items are computed one at a time: the
// next starts only after the last has been loaded into the result register.
// A two-entry queue takes requests while an item is computed, and the
// result register lets the next item start while a result waits.
// When the receiver stalls, the finished result holds on rsp_bus and the
// sequencer waits before overwriting it; requests back up once the queue
// is full.
// Reset (synchronous, active high) empties the queue, drops any item in
// flight and sets sample_count to 100. Depends on qts_pkg, qts_if and all
// qts_ modules.
`default_nettype none
module quintic_trajectory_sampler (
   input  logic       clock,
   input  logic       reset,
   qts_req_if.sink    req_bus,
   qts_rsp_if.source  rsp_bus,
   qts_csr_if.sink    csr_bus
);
   import qts_pkg::*;

   logic [SCNT_W-1:0] sample_count_ff;
   logic              push;
   logic              space;
   logic              pop;
   logic              q_valid;
   item_type          front_item;
   item_type          q_item;
   mdreq_type         mreq;
   mdrsp_type         mrsp;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_bus.valid) begin
         sample_count_ff <= csr_bus.wdata;
      end
   end

   qts_front u_front (
      .req          (req_bus),
      .sample_count (sample_count_ff),
      .space        (space),
      .push         (push),
      .item         (front_item)
   );

   qts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .space    (space),
      .pop      (pop),
      .valid    (q_valid),
      .item_out (q_item)
   );

   qts_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   qts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .pop        (pop),
      .mreq       (mreq),
      .mrsp       (mrsp),
      .rsp        (rsp_bus)
   );
endmodule
`default_nettype wire

// ===== test/quintic_trajectory_sampler_test.sv =====
// quintic_trajectory_sampler_test: self-checking testbench for the quintic
// trajectory sampler; predicts every result, checks it field by field.
// Depends on qts_pkg, qts_if and the quintic_trajectory_sampler RTL.
`default_nettype none
module quintic_trajectory_sampler_test;
   timeunit 1ns;
   timeprecision 1ps;
   import qts_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam longint unsigned WIDE_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned FIX_ONE = 64'd1 << FRAC_BITS;

   typedef struct {
      logic signed [DATA_W-1:0] start_position;
      logic signed [DATA_W-1:0] end_position;
      logic signed [DATA_W-1:0] start_velocity;
      logic signed [DATA_W-1:0] end_velocity;
      logic signed [DATA_W-1:0] start_acceleration;
      logic signed [DATA_W-1:0] end_acceleration;
      logic [DUR_W-1:0]         duration;
      logic [IDX_W-1:0]         sample_index;
   } segment_type;

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
      logic signed [DATA_W-1:0] acceleration;
      logic [IDX_W-1:0]         sample_echo;
      logic                     overflow;
   } setpoint_type;

   logic clock;
   logic reset;
   qts_req_if req_bus();
   qts_rsp_if rsp_bus();
   qts_csr_if csr_bus();

   quintic_trajectory_sampler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   segment_type  segment_q[$];
   setpoint_type setpoint_q[$];
   segment_type  on_bus;
   logic [SCNT_W-1:0] step_count;
   int send_idle_pct;
   int recv_idle_pct;
   int errors;
   int accepted;
   int checked;
   int overflow_seen;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint scale_div(longint x, longint unsigned m, longint unsigned d,
                                        inout bit ov);
      bit neg;
      longint unsigned mag, q, r, res, lo;
      neg = x < 0;
      mag = neg ? 64'd0 - longint'(x) : x;
      q = mag / d;
      r = mag % d;
      if (m != 0 && q > WIDE_LIM / m) begin
         ov = 1;
         res = WIDE_LIM;
      end else begin
         res = q * m;
         lo = (r * m) / d;
         if (res > WIDE_LIM - lo) begin
            ov = 1;
            res = WIDE_LIM;
         end else begin
            res += lo;
         end
      end
      return neg ? -longint'(res) : longint'(res);
   endfunction

   function automatic longint add_sat(longint a, longint b, inout bit ov);
      if (b > 0 && a > longint'(WIDE_LIM) - b) begin
         ov = 1;
         return longint'(WIDE_LIM);
      end
      if (b < 0 && a < -longint'(WIDE_LIM) - b) begin
         ov = 1;
         return -longint'(WIDE_LIM);
      end
      return a + b;
   endfunction

   function automatic logic signed [DATA_W-1:0] fit32(longint x, inout bit ov);
      if (x > 64'sd2147483647) begin
         ov = 1;
         return 32'sh7FFF_FFFF;
      end
      if (x < -64'sd2147483648) begin
         ov = 1;
         return 32'sh8000_0000;
      end
      return x[DATA_W-1:0];
   endfunction

   function automatic setpoint_type sample_quintic(segment_type s, logic [SCNT_W-1:0] count);
      setpoint_type r;
      bit ov;
      longint q0, qf, dq0, dqf, ddq0, ddqf, span, c1, c2, c3, c4, c5, u1, u2, p, v, a;
      longint unsigned dur, ti, tn;
      ov = 0;
      q0 = s.start_position;
      qf = s.end_position;
      dq0 = s.start_velocity;
      dqf = s.end_velocity;
      ddq0 = s.start_acceleration;
      ddqf = s.end_acceleration;
      dur = s.duration;
      ti = s.sample_index;
      tn = count;
      if (dur == 0) dur = 1;
      if (s.sample_index >= count) begin
         ov = 1;
         ti = 1;
         tn = 1;
      end
      span = qf - q0;
      c1 = scale_div(dq0, dur, FIX_ONE, ov);
      c2 = scale_div(scale_div(ddq0, dur, FIX_ONE, ov), dur, FIX_ONE, ov) / 2;
      u1 = scale_div(8 * dqf + 12 * dq0, dur, FIX_ONE, ov);
      u2 = scale_div(scale_div(3 * ddq0 - ddqf, dur, FIX_ONE, ov), dur, FIX_ONE, ov);
      c3 = add_sat(add_sat(20 * span, -u1, ov), -u2, ov) / 2;
      u1 = scale_div(14 * dqf + 16 * dq0, dur, FIX_ONE, ov);
      u2 = scale_div(scale_div(3 * ddq0 - 2 * ddqf, dur, FIX_ONE, ov), dur, FIX_ONE, ov);
      c4 = add_sat(add_sat(-30 * span, u1, ov), u2, ov) / 2;
      u1 = scale_div(6 * dqf + 6 * dq0, dur, FIX_ONE, ov);
      u2 = scale_div(scale_div(ddq0 - ddqf, dur, FIX_ONE, ov), dur, FIX_ONE, ov);
      c5 = add_sat(add_sat(12 * span, -u1, ov), -u2, ov) / 2;

      p = scale_div(c5, ti, tn, ov);
      p = scale_div(add_sat(c4, p, ov), ti, tn, ov);
      p = scale_div(add_sat(c3, p, ov), ti, tn, ov);
      p = scale_div(add_sat(c2, p, ov), ti, tn, ov);
      p = scale_div(add_sat(c1, p, ov), ti, tn, ov);
      p = add_sat(q0, p, ov);

      v = scale_div(scale_div(c5, 5, 1, ov), ti, tn, ov);
      v = scale_div(add_sat(scale_div(c4, 4, 1, ov), v, ov), ti, tn, ov);
      v = scale_div(add_sat(scale_div(c3, 3, 1, ov), v, ov), ti, tn, ov);
      v = scale_div(add_sat(scale_div(c2, 2, 1, ov), v, ov), ti, tn, ov);
      v = add_sat(c1, v, ov);
      v = scale_div(v, FIX_ONE, dur, ov);

      a = scale_div(scale_div(c5, 20, 1, ov), ti, tn, ov);
      a = scale_div(add_sat(scale_div(c4, 12, 1, ov), a, ov), ti, tn, ov);
      a = scale_div(add_sat(scale_div(c3, 6, 1, ov), a, ov), ti, tn, ov);
      a = add_sat(scale_div(c2, 2, 1, ov), a, ov);
      a = scale_div(scale_div(a, FIX_ONE, dur, ov), FIX_ONE, dur, ov);

      r.position = fit32(p, ov);
      r.velocity = fit32(v, ov);
      r.acceleration = fit32(a, ov);
      r.sample_echo = s.sample_index;
      r.overflow = ov;
      return r;
   endfunction

   function automatic segment_type uniform_segment(int pos, int vel, int acc, int unsigned dur,
                                                   int unsigned idx);
      segment_type s;
      s.start_position = pos;
      s.end_position = -pos;
      s.start_velocity = vel;
      s.end_velocity = -vel;
      s.start_acceleration = acc;
      s.end_acceleration = -acc;
      s.duration = DUR_W'(dur);
      s.sample_index = IDX_W'(idx);
      return s;
   endfunction

   function automatic int wiggle(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic segment_type random_segment(logic [SCNT_W-1:0] count);
      segment_type s;
      int unsigned top;
      top = (count == 0) ? 0 : ((count > 1024) ? 1023 : count - 1);
      if ($urandom_range(0, 9) < 2) begin
         s.start_position = $urandom;
         s.end_position = $urandom;
         s.start_velocity = $urandom;
         s.end_velocity = $urandom;
         s.start_acceleration = $urandom;
         s.end_acceleration = $urandom;
         s.duration = DUR_W'($urandom);
      end else begin
         s.start_position = wiggle(1 << 18);
         s.end_position = wiggle(1 << 18);
         s.start_velocity = wiggle(1 << 17);
         s.end_velocity = wiggle(1 << 17);
         s.start_acceleration = wiggle(1 << 17);
         s.end_acceleration = wiggle(1 << 17);
         s.duration = DUR_W'($urandom_range(2000, 1_000_000));
      end
      if ($urandom_range(0, 99) < 85 && count != 0)
         s.sample_index = IDX_W'($urandom_range(0, top));
      else s.sample_index = IDX_W'($urandom_range(0, 1023));
      return s;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      if (errors <= 40)
         $display("mismatch at result %0d: %s got %0d expected %0d", checked, field, got, want);
   endtask

   task automatic write_step_count(logic [SCNT_W-1:0] value);
      csr_bus.wdata <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      step_count = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain;
      @(posedge clock);
      while (segment_q.size() != 0 || req_bus.valid || setpoint_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random(int n);
      repeat (n) segment_q.push_back(random_segment(step_count));
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            setpoint_q.push_back(sample_quintic(on_bus, step_count));
            accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (segment_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = segment_q.pop_front();
               req_bus.start_position <= on_bus.start_position;
               req_bus.end_position <= on_bus.end_position;
               req_bus.start_velocity <= on_bus.start_velocity;
               req_bus.end_velocity <= on_bus.end_velocity;
               req_bus.start_acceleration <= on_bus.start_acceleration;
               req_bus.end_acceleration <= on_bus.end_acceleration;
               req_bus.duration <= on_bus.duration;
               req_bus.sample_index <= on_bus.sample_index;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      setpoint_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (setpoint_q.size() == 0) begin
               report_mismatch("unexpected transaction, position", rsp_bus.position, 0);
            end else begin
               want = setpoint_q.pop_front();
               if (rsp_bus.position !== want.position)
                  report_mismatch("position", rsp_bus.position, want.position);
               if (rsp_bus.velocity !== want.velocity)
                  report_mismatch("velocity", rsp_bus.velocity, want.velocity);
               if (rsp_bus.acceleration !== want.acceleration)
                  report_mismatch("acceleration", rsp_bus.acceleration, want.acceleration);
               if (rsp_bus.sample_echo !== want.sample_echo)
                  report_mismatch("sample_echo", rsp_bus.sample_echo, want.sample_echo);
               if (rsp_bus.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_bus.overflow, want.overflow);
               if (want.overflow) overflow_seen++;
            end
            checked++;
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, setpoint_q.size());
         $display("** quintic_trajectory_sampler: FAILED **");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.start_position = '0;
      req_bus.end_position = '0;
      req_bus.start_velocity = '0;
      req_bus.end_velocity = '0;
      req_bus.start_acceleration = '0;
      req_bus.end_acceleration = '0;
      req_bus.duration = '0;
      req_bus.sample_index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.wdata = '0;
      step_count = SAMPLE_COUNT_RESET;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      errors = 0;
      accepted = 0;
      checked = 0;
      overflow_seen = 0;
      cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed segments at the reset sample count
      segment_q.push_back(uniform_segment(0, 0, 0, 0, 0));
      segment_q.push_back(uniform_segment(65536, 0, 0, 65536, 50));
      segment_q.push_back(uniform_segment(32'sh8000_0000, 0, 0, 32'h7FFF_FFFF, 99));
      segment_q.push_back(uniform_segment(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                          32'h7FFF_FFFF, 1));
      segment_q.push_back(uniform_segment(32'sh8000_0000, 32'sh8000_0000,
                                          32'sh8000_0000, 1, 1023));
      segment_q.push_back(uniform_segment(100000, 20000, -5000, 0, 37));
      segment_q.push_back(uniform_segment(100000, 20000, -5000, 1, 37));
      segment_q.push_back(uniform_segment(200000, -30000, 7000, 131072, 100));
      segment_q.push_back(uniform_segment(200000, -30000, 7000, 131072, 1023));
      segment_q.push_back(uniform_segment(-1, 1, -1, 3, 98));
      segment_q.push_back(uniform_segment(12345, 678, 90, 300000, 0));
      segment_q.push_back(uniform_segment(32'sh4000_0000, 32'sh1000_0000, 32'sh0100_0000,
                                          32'h0001_0000, 75));
      queue_random(230);
      drain();

      write_step_count(SCNT_W'(1));
      send_idle_pct = 54;
      segment_q.push_back(uniform_segment(50000, 1000, 100, 65536, 0));
      segment_q.push_back(uniform_segment(50000, 1000, 100, 65536, 1));
      queue_random(200);
      drain();

      write_step_count(SCNT_W'(1024));
      send_idle_pct = 0;
      recv_idle_pct = 54;
      segment_q.push_back(uniform_segment(80000, -4000, 300, 200000, 1023));
      segment_q.push_back(uniform_segment(80000, -4000, 300, 200000, 512));
      queue_random(260);
      drain();

      write_step_count(SCNT_W'(2047));
      send_idle_pct = 26;
      recv_idle_pct = 26;
      queue_random(230);
      drain();

      write_step_count(SCNT_W'(0));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      segment_q.push_back(uniform_segment(70000, 300, 20, 90000, 0));
      queue_random(40);
      drain();

      // sender holds off mid phase until every result is back
      write_step_count(SCNT_W'(7));
      queue_random(120);
      drain();
      queue_random(120);
      drain();

      write_step_count(SCNT_W'(1000));
      send_idle_pct = 26;
      recv_idle_pct = 54;
      queue_random(300);
      drain();

      repeat (3200) @(posedge clock);
      $display("covered %0d segments, %0d results checked (%0d with overflow)",
               accepted, checked, overflow_seen);
      $display("sample counts 100, 1, 1024, 2047, 0, 7 and 1000 under mixed idling");
      if (errors == 0 && setpoint_q.size() == 0) begin
         $display("** quintic_trajectory_sampler: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, setpoint_q.size());
         $display("** quintic_trajectory_sampler: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
